// ===== hdl/pcxrle_pkg.sv =====
// Shared constants, codes and controller/datapath types for the PCX run-length decoder.
package pcxrle_pkg;

  // Field widths
  localparam int BYTE_W     = 8;
  localparam int COORD_W    = 16;
  localparam int SCREEN_W   = 17;
  localparam int RUN_W      = 6;
  localparam int HIDX_W     = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_WIDTH = 2'd2;

  // Header byte positions
  localparam logic [HIDX_W-1:0] HDR_MANUFACTURER = 7'd0;
  localparam logic [HIDX_W-1:0] HDR_ENCODING     = 7'd2;
  localparam logic [HIDX_W-1:0] HDR_BPP          = 7'd3;
  localparam logic [HIDX_W-1:0] HDR_XMIN_LO      = 7'd4;
  localparam logic [HIDX_W-1:0] HDR_XMIN_HI      = 7'd5;
  localparam logic [HIDX_W-1:0] HDR_YMIN_LO      = 7'd6;
  localparam logic [HIDX_W-1:0] HDR_YMIN_HI      = 7'd7;
  localparam logic [HIDX_W-1:0] HDR_XMAX_LO      = 7'd8;
  localparam logic [HIDX_W-1:0] HDR_XMAX_HI      = 7'd9;
  localparam logic [HIDX_W-1:0] HDR_YMAX_LO      = 7'd10;
  localparam logic [HIDX_W-1:0] HDR_YMAX_HI      = 7'd11;
  localparam logic [HIDX_W-1:0] HDR_PLANES       = 7'd65;
  localparam logic [HIDX_W-1:0] HDR_PALETTE      = 7'd68;
  localparam logic [HIDX_W-1:0] HDR_LAST         = 7'd127;

  // Expected header values
  localparam logic [BYTE_W-1:0] MANUFACTURER_ID = 8'd10;
  localparam logic [BYTE_W-1:0] ENCODING_RLE    = 8'd1;
  localparam logic [BYTE_W-1:0] BITS_PER_PIXEL  = 8'd8;
  localparam logic [BYTE_W-1:0] PLANE_COUNT     = 8'd1;
  localparam logic [BYTE_W-1:0] PALETTE_MAX     = 8'd10;

  // Run marker: top two bits set
  localparam logic [1:0] RUN_MARK = 2'b11;

  // Result kinds
  localparam logic KIND_PIXEL  = 1'b0;
  localparam logic KIND_REJECT = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic hdr_byte;   // check and store one header byte
    logic hdr_finish; // header complete, latch picture size
    logic reject;     // issue a header-rejected word
    logic lit_pixel;  // decode a literal pixel from the input byte
    logic run_load;   // take the run count from the input byte
    logic run_start;  // latch the colour of a run
    logic run_step;   // decode one pixel of the current run
    logic flush;      // send the held run pixel with last set
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic hdr_ok;        // current header byte passes its check
    logic hdr_end;       // current header byte is the final one
    logic run_code;      // input byte is a run marker
    logic run_zero;      // loaded run count is zero
    logic run_last;      // the current run step is the final one
    logic pic_done_step; // the current pixel completes the final row
    logic pend_valid;    // a run pixel is held back
    logic out_free;      // the output register can take a word
  } sts_t;

endpackage

// ===== hdl/pcxrle_in_if.sv =====
// Input channel: one raw file byte per word.
interface pcxrle_in_if;
  import pcxrle_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] file_byte;
  logic              first_byte;

  modport source (output valid, output file_byte, output first_byte, input ready);
  modport sink   (input valid, input file_byte, input first_byte, output ready);
endinterface

// ===== hdl/pcxrle_out_if.sv =====
// Result channel: one pixel or header-rejected word per transfer.
interface pcxrle_out_if;
  import pcxrle_pkg::*;

  logic                valid;
  logic                ready;
  logic                kind;
  logic [SCREEN_W-1:0] screen_x;
  logic [SCREEN_W-1:0] screen_y;
  logic [BYTE_W-1:0]   color;
  logic                picture_done;
  logic                last;

  modport source (output valid, output kind, output screen_x, output screen_y,
                  output color, output picture_done, output last, input ready);
  modport sink   (input valid, input kind, input screen_x, input screen_y,
                  input color, input picture_done, input last, output ready);
endinterface

// ===== hdl/pcx_rle_pixel_decoder.sv =====
// Top level of the PCX run-length pixel decoder: controller plus datapath.
//
//   Channel  Direction  Word
//   in_ch    sink       file_byte, first_byte
//   out_ch   source     kind, screen_x, screen_y, color, picture_done, last
//   cfg_*    write      origin_x, origin_y, full_width_mode
//
// Header, literal and run marker bytes are handled as each is accepted; a literal's word lands in the output
// register. The colour byte of a run is accepted first; the run sequencer then steps through the run
// pixel by pixel and finally releases the held last pixel. A count of zero expands to nothing, and a
// run that completes the picture stops at that pixel.
// Reset is synchronous and active low; no clearing pass is needed.
// A stalled output holds off both input and the run sequencer until the word is taken.
module pcx_rle_pixel_decoder (
  input  logic                                clk,
  input  logic                                rst_n,
  pcxrle_in_if.sink                           in_ch,
  pcxrle_out_if.source                        out_ch,
  input  logic                                cfg_we,
  input  logic [pcxrle_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pcxrle_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pcxrle_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Phase sequencing
  pcxrle_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_first_byte (in_ch.first_byte),
    .in_ready      (in_ch.ready),
    .sts           (sts),
    .cmd           (cmd)
  );

  // Header, position and output logic
  pcxrle_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_file_byte     (in_ch.file_byte),
    .in_first_byte    (in_ch.first_byte),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_kind         (out_ch.kind),
    .out_screen_x     (out_ch.screen_x),
    .out_screen_y     (out_ch.screen_y),
    .out_color        (out_ch.color),
    .out_picture_done (out_ch.picture_done),
    .out_last         (out_ch.last)
  );

endmodule

// ===== hdl/pcxrle_dp.sv =====
// Datapath: header checks, window and position registers, pixel mapping and output staging.
module pcxrle_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [pcxrle_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pcxrle_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [pcxrle_pkg::BYTE_W-1:0]       in_file_byte,
  input  logic                                in_first_byte,
  input  pcxrle_pkg::cmd_t                    cmd,
  output pcxrle_pkg::sts_t                    sts,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_kind,
  output logic [pcxrle_pkg::SCREEN_W-1:0]     out_screen_x,
  output logic [pcxrle_pkg::SCREEN_W-1:0]     out_screen_y,
  output logic [pcxrle_pkg::BYTE_W-1:0]       out_color,
  output logic                                out_picture_done,
  output logic                                out_last
);
  import pcxrle_pkg::*;

  // Configuration registers
  logic [COORD_W-1:0] origin_x_r;
  logic [COORD_W-1:0] origin_y_r;
  logic               full_r;

  // Header and picture state
  logic [HIDX_W-1:0]   header_index_r;
  logic [COORD_W-1:0]  win_min_x_r, win_min_y_r, win_max_x_r, win_max_y_r;
  logic [SCREEN_W-1:0] width_r, height_r;
  logic [COORD_W-1:0]  column_r, row_r;
  logic [RUN_W-1:0]    run_len_r;
  logic [BYTE_W-1:0]   run_color_r;

  // Held run pixel and output register
  logic                pend_valid_r;
  logic [SCREEN_W-1:0] pend_x_r, pend_y_r;
  logic [BYTE_W-1:0]   pend_color_r;
  logic                pend_done_r;
  logic                out_valid_r;
  logic                out_kind_r;
  logic [SCREEN_W-1:0] out_x_r, out_y_r;
  logic [BYTE_W-1:0]   out_color_r;
  logic                out_done_r;
  logic                out_last_r;

  logic [HIDX_W-1:0]   hidx;
  logic                hdr_ok;
  logic [COORD_W-1:0]  new_max_y;
  logic                out_free;
  logic [BYTE_W-1:0]   pix_color;
  logic [SCREEN_W-1:0] col_inc, col_inc2, row_inc;
  logic                wrap, last_row, pic_done_step;
  logic                shown, pix_done;
  logic [COORD_W-1:0]  col_map;
  logic [SCREEN_W-1:0] pix_x, pix_y;
  logic                pix_step;

  // A first byte always stands at header position zero
  assign hidx      = in_first_byte ? '0 : header_index_r;
  assign new_max_y = {in_file_byte, win_max_y_r[BYTE_W-1:0]};

  // Per-byte header check
  always_comb begin
    hdr_ok = 1'b1;
    case (hidx)
      HDR_MANUFACTURER: hdr_ok = (in_file_byte == MANUFACTURER_ID);
      HDR_ENCODING:     hdr_ok = (in_file_byte == ENCODING_RLE);
      HDR_BPP:          hdr_ok = (in_file_byte == BITS_PER_PIXEL);
      HDR_YMAX_HI:      hdr_ok = (win_max_x_r >= win_min_x_r) && (new_max_y >= win_min_y_r);
      HDR_PLANES:       hdr_ok = (in_file_byte == PLANE_COUNT);
      HDR_PALETTE:      hdr_ok = (in_file_byte <= PALETTE_MAX);
      default:          hdr_ok = 1'b1;
    endcase
  end

  // Pixel position arithmetic, shared by literal and run pixels
  assign pix_color     = cmd.run_step ? run_color_r : in_file_byte;
  assign pix_step      = cmd.lit_pixel || cmd.run_step;
  assign col_inc       = {1'b0, column_r} + SCREEN_W'(1);
  assign col_inc2      = {1'b0, column_r} + SCREEN_W'(2);
  assign row_inc       = {1'b0, row_r} + SCREEN_W'(1);
  assign wrap          = (col_inc >= width_r);
  assign last_row      = (row_inc == height_r);
  assign pic_done_step = wrap && (row_inc >= height_r);
  assign shown         = full_r || column_r[0];
  assign pix_done      = full_r ? (last_row && (col_inc == width_r))
                                : (last_row && (col_inc2 >= width_r));
  assign col_map       = full_r ? column_r : (column_r >> 1);
  assign pix_x         = {1'b0, origin_x_r} + {1'b0, col_map};
  assign pix_y         = {1'b0, origin_y_r} + {1'b0, row_r};
  assign out_free      = !out_valid_r || out_ready;

  always_comb begin
    sts               = '0;
    sts.hdr_ok        = hdr_ok;
    sts.hdr_end       = (hidx == HDR_LAST);
    sts.run_code      = (in_file_byte[BYTE_W-1 -: 2] == RUN_MARK);
    sts.run_zero      = (run_len_r == '0);
    sts.run_last      = (run_len_r == RUN_W'(1));
    sts.pic_done_step = pic_done_step;
    sts.pend_valid    = pend_valid_r;
    sts.out_free      = out_free;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      full_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X:   origin_x_r <= cfg_data[COORD_W-1:0];
        REG_ORIGIN_Y:   origin_y_r <= cfg_data[COORD_W-1:0];
        REG_FULL_WIDTH: full_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Header index, window and picture position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_index_r <= '0;
      win_min_x_r    <= '0;
      win_min_y_r    <= '0;
      win_max_x_r    <= '0;
      win_max_y_r    <= '0;
      width_r        <= '0;
      height_r       <= '0;
      column_r       <= '0;
      row_r          <= '0;
      run_len_r      <= '0;
    end else begin
      // Restart clears the picture state
      if (cmd.hdr_byte && in_first_byte) begin
        header_index_r <= '0;
        win_min_x_r    <= '0;
        win_min_y_r    <= '0;
        win_max_x_r    <= '0;
        win_max_y_r    <= '0;
        column_r       <= '0;
        row_r          <= '0;
        run_len_r      <= '0;
      end
      if (cmd.hdr_byte) begin
        case (hidx)
          HDR_XMIN_LO: win_min_x_r[7:0]  <= in_file_byte;
          HDR_XMIN_HI: win_min_x_r[15:8] <= in_file_byte;
          HDR_YMIN_LO: win_min_y_r[7:0]  <= in_file_byte;
          HDR_YMIN_HI: win_min_y_r[15:8] <= in_file_byte;
          HDR_XMAX_LO: win_max_x_r[7:0]  <= in_file_byte;
          HDR_XMAX_HI: win_max_x_r[15:8] <= in_file_byte;
          HDR_YMAX_LO: win_max_y_r[7:0]  <= in_file_byte;
          HDR_YMAX_HI: win_max_y_r[15:8] <= in_file_byte;
          default: ;
        endcase
        if (hdr_ok && (hidx != HDR_LAST)) begin
          header_index_r <= hidx + HIDX_W'(1);
        end
      end
      if (cmd.hdr_finish) begin
        width_r  <= {1'b0, win_max_x_r} - {1'b0, win_min_x_r} + SCREEN_W'(1);
        height_r <= {1'b0, win_max_y_r} - {1'b0, win_min_y_r} + SCREEN_W'(1);
        column_r <= '0;
        row_r    <= '0;
      end
      if (cmd.run_load) begin
        run_len_r <= in_file_byte[RUN_W-1:0];
      end
      // Step along the row, wrapping at the picture width
      if (pix_step) begin
        if (wrap) begin
          column_r <= '0;
          row_r    <= row_inc[COORD_W-1:0];
        end else begin
          column_r <= col_inc[COORD_W-1:0];
        end
      end
      if (cmd.run_step) begin
        run_len_r <= run_len_r - RUN_W'(1);
      end
    end
  end

  // Run colour
  always_ff @(posedge clk) begin
    if (cmd.run_start) begin
      run_color_r <= in_file_byte;
    end
  end

  // Held run pixel and output word staging
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.reject) begin
        out_valid_r <= 1'b1;
        out_kind_r  <= KIND_REJECT;
        out_x_r     <= '0;
        out_y_r     <= '0;
        out_color_r <= '0;
        out_done_r  <= 1'b0;
        out_last_r  <= 1'b1;
      end
      if (cmd.lit_pixel && shown) begin
        out_valid_r <= 1'b1;
        out_kind_r  <= KIND_PIXEL;
        out_x_r     <= pix_x;
        out_y_r     <= pix_y;
        out_color_r <= pix_color;
        out_done_r  <= pix_done;
        out_last_r  <= 1'b1;
      end
      // A run pixel waits until the next one shows whether it is the final word
      if (cmd.run_step && shown) begin
        if (pend_valid_r) begin
          out_valid_r <= 1'b1;
          out_kind_r  <= KIND_PIXEL;
          out_x_r     <= pend_x_r;
          out_y_r     <= pend_y_r;
          out_color_r <= pend_color_r;
          out_done_r  <= pend_done_r;
          out_last_r  <= 1'b0;
        end
        pend_valid_r <= 1'b1;
        pend_x_r     <= pix_x;
        pend_y_r     <= pix_y;
        pend_color_r <= pix_color;
        pend_done_r  <= pix_done;
      end
      if (cmd.flush && pend_valid_r) begin
        out_valid_r  <= 1'b1;
        out_kind_r   <= KIND_PIXEL;
        out_x_r      <= pend_x_r;
        out_y_r      <= pend_y_r;
        out_color_r  <= pend_color_r;
        out_done_r   <= pend_done_r;
        out_last_r   <= 1'b1;
        pend_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_screen_x     = out_x_r;
  assign out_screen_y     = out_y_r;
  assign out_color        = out_color_r;
  assign out_picture_done = out_done_r;
  assign out_last         = out_last_r;

endmodule

// ===== hdl/pcxrle_ctrl.sv =====
// Controller: decoding phase state machine and run sequencer.
module pcxrle_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_first_byte,
  output logic             in_ready,
  input  pcxrle_pkg::sts_t sts,
  output pcxrle_pkg::cmd_t cmd
);
  import pcxrle_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HEADER,
    S_DATA,
    S_RUN,
    S_EMIT,
    S_FLUSH_DATA,
    S_FLUSH_DONE,
    S_DONE,
    S_REJECT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_acc;

  // Input is held off while a run is being expanded or the output register is full
  assign in_ready = sts.out_free && !(state_r inside {S_EMIT, S_FLUSH_DATA, S_FLUSH_DONE});
  assign in_acc   = in_valid && in_ready;

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    if (in_acc && in_first_byte) begin
      cmd.hdr_byte = 1'b1;
      if (!sts.hdr_ok) begin
        cmd.reject = 1'b1;
        state_nxt  = S_REJECT;
      end else begin
        state_nxt = S_HEADER;
      end
    end else begin
      case (state_r)
        S_HEADER: begin
          if (in_acc) begin
            cmd.hdr_byte = 1'b1;
            if (!sts.hdr_ok) begin
              cmd.reject = 1'b1;
              state_nxt  = S_REJECT;
            end else if (sts.hdr_end) begin
              cmd.hdr_finish = 1'b1;
              state_nxt      = S_DATA;
            end
          end
        end
        S_DATA: begin
          if (in_acc) begin
            if (sts.run_code) begin
              cmd.run_load = 1'b1;
              state_nxt    = S_RUN;
            end else begin
              cmd.lit_pixel = 1'b1;
              if (sts.pic_done_step) begin
                state_nxt = S_DONE;
              end
            end
          end
        end
        S_RUN: begin
          if (in_acc) begin
            if (sts.run_zero) begin
              state_nxt = S_DATA;
            end else begin
              cmd.run_start = 1'b1;
              state_nxt     = S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (sts.out_free) begin
            cmd.run_step = 1'b1;
            if (sts.pic_done_step) begin
              state_nxt = S_FLUSH_DONE;
            end else if (sts.run_last) begin
              state_nxt = S_FLUSH_DATA;
            end
          end
        end
        S_FLUSH_DATA: begin
          if (!sts.pend_valid || sts.out_free) begin
            cmd.flush = 1'b1;
            state_nxt = S_DATA;
          end
        end
        S_FLUSH_DONE: begin
          if (!sts.pend_valid || sts.out_free) begin
            cmd.flush = 1'b1;
            state_nxt = S_DONE;
          end
        end
        default: ;
      endcase
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== bench/pcxrle_pixel_check.sv =====
// Checker for the PCX decoder: predicts every result word and compares it with the output channel.
module pcxrle_pixel_check (
  input  logic                              clk,
  input  logic                              rst_n,
  pcxrle_in_if                              in_ch,
  pcxrle_out_if                             out_ch,
  input  logic                              cfg_we,
  input  logic [pcxrle_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcxrle_pkg::CFG_DATA_W-1:0] cfg_data,
  output int unsigned                       mismatches,
  output int unsigned                       words_waiting
);
  import pcxrle_pkg::*;

  typedef enum logic [2:0] {
    DEC_IDLE,
    DEC_HEADER,
    DEC_DATA,
    DEC_RUN,
    DEC_DONE,
    DEC_REJECT
  } decode_phase_t;

  typedef struct packed {
    logic                kind;
    logic [SCREEN_W-1:0] screen_x;
    logic [SCREEN_W-1:0] screen_y;
    logic [BYTE_W-1:0]   color;
    logic                picture_done;
    logic                last;
  } pixel_word_t;

  // Decoder state as seen from outside, plus the view registers.
  decode_phase_t      dec_phase;
  logic [HIDX_W-1:0]  hdr_idx;
  logic [COORD_W-1:0] min_x, min_y, max_x, max_y;
  logic [COORD_W:0]   col, row;
  logic [RUN_W-1:0]   run_len;
  logic [COORD_W-1:0] org_x, org_y;
  logic               full_width;

  pixel_word_t expected_words[$];
  pixel_word_t byte_words[$];
  int unsigned bad_count;

  function automatic string describe(input pixel_word_t w);
    return $sformatf("kind=%0d x=%0d y=%0d colour=%0d done=%0d last=%0d",
                     w.kind, w.screen_x, w.screen_y, w.color, w.picture_done, w.last);
  endfunction

  // Checks one header byte and captures the window fields as they go past.
  function automatic bit header_ok(input logic [HIDX_W-1:0] idx, input logic [BYTE_W-1:0] b);
    case (idx)
      HDR_MANUFACTURER: return b == MANUFACTURER_ID;
      HDR_ENCODING:     return b == ENCODING_RLE;
      HDR_BPP:          return b == BITS_PER_PIXEL;
      HDR_XMIN_LO:      min_x[7:0]  = b;
      HDR_XMIN_HI:      min_x[15:8] = b;
      HDR_YMIN_LO:      min_y[7:0]  = b;
      HDR_YMIN_HI:      min_y[15:8] = b;
      HDR_XMAX_LO:      max_x[7:0]  = b;
      HDR_XMAX_HI:      max_x[15:8] = b;
      HDR_YMAX_LO:      max_y[7:0]  = b;
      HDR_YMAX_HI: begin
        max_y[15:8] = b;
        return max_x >= min_x && max_y >= min_y;
      end
      HDR_PLANES:       return b == PLANE_COUNT;
      HDR_PALETTE:      return b <= PALETTE_MAX;
      default:          return 1'b1;
    endcase
    return 1'b1;
  endfunction

  // Places one pixel; in half mode only odd columns produce a word.
  function automatic void place_pixel(input logic [BYTE_W-1:0] c);
    int unsigned w, h;
    bit          last_row;
    pixel_word_t pw;
    w = 32'(max_x) - 32'(min_x) + 1;
    h = 32'(max_y) - 32'(min_y) + 1;
    last_row = (32'(row) + 1 == h);
    pw = '0;
    pw.kind = KIND_PIXEL;
    pw.color = c;
    pw.screen_y = SCREEN_W'(32'(org_y) + 32'(row));
    if (full_width) begin
      pw.screen_x = SCREEN_W'(32'(org_x) + 32'(col));
      pw.picture_done = last_row && (32'(col) + 1 == w);
      byte_words.push_back(pw);
    end else if (col[0]) begin
      pw.screen_x = SCREEN_W'(32'(org_x) + 32'(col >> 1));
      pw.picture_done = last_row && (32'(col) + 2 >= w);
      byte_words.push_back(pw);
    end
    if (32'(col) + 1 >= w) begin
      col = '0;
      row = row + 1'b1;
      if (32'(row) >= h) dec_phase = DEC_DONE;
    end else begin
      col = col + 1'b1;
    end
  endfunction

  // Works out the words caused by one accepted file byte.
  function automatic void decode_byte(input logic [BYTE_W-1:0] b, input logic first);
    pixel_word_t      pw;
    logic [RUN_W-1:0] n;
    byte_words.delete();
    if (first) begin
      dec_phase = DEC_HEADER;
      hdr_idx = '0;
      min_x = '0; min_y = '0; max_x = '0; max_y = '0;
      col = '0; row = '0; run_len = '0;
    end
    case (dec_phase)
      DEC_HEADER: begin
        if (!header_ok(hdr_idx, b)) begin
          pw = '0;
          pw.kind = KIND_REJECT;
          byte_words.push_back(pw);
          dec_phase = DEC_REJECT;
        end else if (hdr_idx == HDR_LAST) begin
          dec_phase = DEC_DATA;
          col = '0; row = '0; run_len = '0;
        end else begin
          hdr_idx = hdr_idx + 1'b1;
        end
      end
      DEC_DATA: begin
        if (b[7:6] == RUN_MARK) begin
          run_len = b[RUN_W-1:0];
          dec_phase = DEC_RUN;
        end else begin
          place_pixel(b);
        end
      end
      DEC_RUN: begin
        dec_phase = DEC_DATA;
        n = run_len;
        for (int k = 0; k < n && dec_phase == DEC_DATA; k++) place_pixel(b);
        run_len = '0;
      end
      default: ;
    endcase
    if (byte_words.size() > 0) byte_words[$].last = 1'b1;
    foreach (byte_words[i]) expected_words.push_back(byte_words[i]);
  endfunction

  // Register writes first, then the output word, then the new input byte.
  always @(posedge clk) begin : monitor
    pixel_word_t got, want;
    if (!rst_n) begin
      dec_phase = DEC_IDLE;
      hdr_idx = '0;
      min_x = '0; min_y = '0; max_x = '0; max_y = '0;
      col = '0; row = '0; run_len = '0;
      org_x = '0; org_y = '0; full_width = 1'b0;
      expected_words.delete();
      bad_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ORIGIN_X:   org_x = cfg_data;
          REG_ORIGIN_Y:   org_y = cfg_data;
          REG_FULL_WIDTH: full_width = cfg_data[0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        got.kind = out_ch.kind;
        got.screen_x = out_ch.screen_x;
        got.screen_y = out_ch.screen_y;
        got.color = out_ch.color;
        got.picture_done = out_ch.picture_done;
        got.last = out_ch.last;
        if (expected_words.size() == 0) begin
          bad_count++;
          if (bad_count <= 10)
            $display("%0t: unexpected word: expected none, got %s", $time, describe(got));
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            bad_count++;
            if (bad_count <= 10)
              $display("%0t: word mismatch: expected %s, got %s",
                       $time, describe(want), describe(got));
          end
        end
      end
      if (in_ch.valid && in_ch.ready) decode_byte(in_ch.file_byte, in_ch.first_byte);
    end
    mismatches <= bad_count;
    words_waiting <= expected_words.size();
  end

endmodule

// ===== bench/tb_pcx_rle_pixel_decoder.sv =====
// Testbench top for the PCX decoder: clock, reset, file-byte stimulus, result sink and verdict.
module tb_pcx_rle_pixel_decoder;
  import pcxrle_pkg::*;

  localparam int HDR_BYTES      = int'(HDR_LAST) + 1;
  localparam int SETTLE_CYCLES  = 100;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef enum {
    FAULT_NONE,
    FAULT_MANUF,
    FAULT_ENCODING,
    FAULT_DEPTH,
    FAULT_X_INVERTED,
    FAULT_Y_INVERTED,
    FAULT_PLANES,
    FAULT_PALETTE
  } hdr_fault_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int unsigned           mismatches;
  int unsigned           words_waiting;
  int unsigned           quiet_cycles = 0;
  bit                    idle_on = 1'b1;
  bit                    hold_req = 1'b0;

  // Header contents of the picture being sent.
  hdr_fault_t            pic_fault;
  logic [COORD_W-1:0]    pic_xmin, pic_ymin, pic_xmax, pic_ymax;

  pcxrle_in_if  in_ch();
  pcxrle_out_if out_ch();

  pcx_rle_pixel_decoder DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pcxrle_pixel_check u_pixel_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .words_waiting (words_waiting)
  );

  always #1 clk = ~clk;

  // Watchdog: ends the run when no word moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** pcx_rle_pixel_decoder: FAILED **");
      $finish;
    end
  end

  // Result sink: random stalls, ready stretches and one long hold-off on request.
  initial begin : result_sink
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Offers one file byte, with an occasional idle burst first, and waits for it to be taken.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic first);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.file_byte <= b;
    in_ch.first_byte <= first;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Waits until every expected word has arrived and any run still in progress has ended.
  task automatic drain_words();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (words_waiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all three view registers back to back.
  task automatic set_view(input logic [COORD_W-1:0] ox, input logic [COORD_W-1:0] oy,
                          input logic fw);
    cfg_we <= 1'b1;
    cfg_index <= REG_ORIGIN_X;
    cfg_data <= ox;
    @(posedge clk);
    cfg_index <= REG_ORIGIN_Y;
    cfg_data <= oy;
    @(posedge clk);
    cfg_index <= REG_FULL_WIDTH;
    cfg_data <= {{(CFG_DATA_W-1){1'b0}}, fw};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Header byte for the current picture, with the selected check broken if any.
  function automatic logic [BYTE_W-1:0] header_byte_for(input logic [HIDX_W-1:0] idx);
    case (idx)
      HDR_MANUFACTURER:
        return (pic_fault == FAULT_MANUF) ?
               8'(MANUFACTURER_ID + $urandom_range(1, 255)) : MANUFACTURER_ID;
      HDR_ENCODING:
        return (pic_fault == FAULT_ENCODING) ?
               8'(ENCODING_RLE + $urandom_range(1, 255)) : ENCODING_RLE;
      HDR_BPP:
        return (pic_fault == FAULT_DEPTH) ?
               8'(BITS_PER_PIXEL + $urandom_range(1, 255)) : BITS_PER_PIXEL;
      HDR_XMIN_LO: return pic_xmin[7:0];
      HDR_XMIN_HI: return pic_xmin[15:8];
      HDR_YMIN_LO: return pic_ymin[7:0];
      HDR_YMIN_HI: return pic_ymin[15:8];
      HDR_XMAX_LO: return pic_xmax[7:0];
      HDR_XMAX_HI: return pic_xmax[15:8];
      HDR_YMAX_LO: return pic_ymax[7:0];
      HDR_YMAX_HI: return pic_ymax[15:8];
      HDR_PLANES:
        return (pic_fault == FAULT_PLANES) ?
               8'(PLANE_COUNT + $urandom_range(1, 255)) : PLANE_COUNT;
      HDR_PALETTE:
        return (pic_fault == FAULT_PALETTE) ?
               8'($urandom_range(PALETTE_MAX + 1, 255)) : 8'($urandom_range(0, PALETTE_MAX));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Random pixel data: literals, short and long runs, and runs of zero.
  task automatic send_run_data(input int unsigned budget);
    int unsigned drawn;
    int unsigned n;
    drawn = 0;
    while (drawn < budget) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          send_byte(8'($urandom_range(0, 8'hBF)), 1'b0);
          drawn++;
        end
        5, 6, 7: begin
          n = $urandom_range(1, 6);
          send_byte({RUN_MARK, RUN_W'(n)}, 1'b0);
          send_byte(8'($urandom), 1'b0);
          drawn += n;
        end
        8: begin
          n = $urandom_range(7, 63);
          send_byte({RUN_MARK, RUN_W'(n)}, 1'b0);
          send_byte(8'($urandom), 1'b0);
          drawn += n;
        end
        default: begin
          send_byte({RUN_MARK, RUN_W'(0)}, 1'b0);
          send_byte(8'($urandom), 1'b0);
        end
      endcase
    end
  endtask

  // Sends a header (possibly cut short) and, when it is good and whole, some pixel data.
  task automatic send_picture(input logic [COORD_W-1:0] xmin, input logic [COORD_W-1:0] ymin,
                              input int unsigned w, input int unsigned h,
                              input hdr_fault_t fault, input int unsigned budget,
                              input int unsigned hdr_len);
    pic_fault = fault;
    pic_xmin = xmin;
    pic_ymin = ymin;
    pic_xmax = COORD_W'(32'(xmin) + w - 1);
    pic_ymax = COORD_W'(32'(ymin) + h - 1);
    if (fault == FAULT_X_INVERTED) begin
      if (pic_xmin == 0) pic_xmin = 1;
      pic_xmax = COORD_W'($urandom_range(0, pic_xmin - 1));
    end
    if (fault == FAULT_Y_INVERTED) begin
      if (pic_ymin == 0) pic_ymin = 1;
      pic_ymax = COORD_W'($urandom_range(0, pic_ymin - 1));
    end
    for (int i = 0; i < hdr_len; i++) send_byte(header_byte_for(HIDX_W'(i)), i == 0);
    if (fault == FAULT_NONE && hdr_len == HDR_BYTES) begin
      send_run_data(budget);
    end else begin
      repeat ($urandom_range(0, 3)) send_byte(8'($urandom), 1'b0);
    end
  endtask

  // Stray bytes, now and then with a restart mark.
  task automatic send_noise();
    repeat ($urandom_range(4, 20)) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
  endtask

  initial begin : stimulus
    int unsigned        w, h, budget;
    logic [COORD_W-1:0] xmin, ymin;
    hdr_fault_t         fault;
    in_ch.valid <= 1'b0;
    in_ch.file_byte <= '0;
    in_ch.first_byte <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= REG_ORIGIN_X;
    cfg_data <= '0;
    rst_n <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Bytes before any header are dropped.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hC5, 1'b0);

    // Half mode from reset: literal extremes, a zero run, a short run, and a full-length
    // run that overruns the end of the picture, then a byte after completion.
    send_picture(16'd0, 16'd0, 5, 2, FAULT_NONE, 0, HDR_BYTES);
    send_byte(8'h00, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte({RUN_MARK, 6'd0}, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte({RUN_MARK, 6'd3}, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte({RUN_MARK, 6'd63}, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h12, 1'b0);

    // Every header check failing in turn.
    for (int f = FAULT_MANUF; f <= FAULT_PALETTE; f++)
      send_picture(16'd3, 16'd4, 3, 2, hdr_fault_t'(f), 0, HDR_BYTES);

    // Restart part way through a header, then a good picture.
    send_picture(16'd10, 16'd20, 3, 3, FAULT_NONE, 0, 60);
    send_picture(16'd10, 16'd20, 3, 3, FAULT_NONE, 12, HDR_BYTES);

    // Full mode at the largest origin and window corner.
    drain_words();
    set_view(16'hFFFF, 16'hFFFF, 1'b1);
    send_picture(16'hFFFC, 16'hFFFE, 4, 2, FAULT_NONE, 10, HDR_BYTES);

    // Widest possible window, abandoned by the next restart.
    send_picture(16'd0, 16'd0, 65536, 65536, FAULT_NONE, 150, HDR_BYTES);

    // Half mode with a one-column window shows nothing.
    drain_words();
    set_view(16'd0, 16'd0, 1'b0);
    send_picture(16'hFFFF, 16'd3, 1, 3, FAULT_NONE, 4, HDR_BYTES);

    // Half mode with an even width.
    drain_words();
    set_view(16'd1234, 16'd7, 1'b0);
    send_picture(16'd500, 16'd600, 6, 3, FAULT_NONE, 20, HDR_BYTES);

    // Random pictures; the last few run without idling.
    for (int pic = 0; pic < 16; pic++) begin
      if (pic == 12) idle_on = 1'b0;
      if (pic == 3) begin
        // The sink holds off while data keeps coming, so the decoder backs up.
        drain_words();
        set_view(16'd100, 16'd200, 1'b1);
        send_picture(16'd40, 16'd50, 30, 3, FAULT_NONE, 0, HDR_BYTES);
        hold_req = 1'b1;
        send_run_data(90);
      end else begin
        if ($urandom_range(0, 2) == 0) begin
          drain_words();
          case ($urandom_range(0, 3))
            0:       set_view(16'd0, 16'd0, 1'b0);
            1:       set_view(16'hFFFF, 16'hFFFF, 1'b1);
            default: set_view(16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
          endcase
        end
        if ($urandom_range(0, 5) == 0) send_noise();
        w = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 10);
        h = (w > 10) ? $urandom_range(1, 2) : $urandom_range(1, 5);
        xmin = COORD_W'($urandom_range(0, 65536 - w));
        ymin = COORD_W'($urandom_range(0, 65536 - h));
        fault = ($urandom_range(0, 5) == 0) ?
                hdr_fault_t'($urandom_range(FAULT_MANUF, FAULT_PALETTE)) : FAULT_NONE;
        budget = ($urandom_range(0, 5) == 0) ? $urandom_range(0, w * h)
                                              : w * h + $urandom_range(0, 3);
        send_picture(xmin, ymin, w, h, fault, budget, HDR_BYTES);
      end
    end

    drain_words();
    if (mismatches == 0 && words_waiting == 0) begin
      $display("** pcx_rle_pixel_decoder: PASSED **");
    end else begin
      $display("** pcx_rle_pixel_decoder: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/pcxrle_pkg.sv
hdl/pcxrle_in_if.sv
hdl/pcxrle_out_if.sv
hdl/pcxrle_dp.sv
hdl/pcxrle_ctrl.sv
hdl/pcx_rle_pixel_decoder.sv
bench/pcxrle_pixel_check.sv
bench/tb_pcx_rle_pixel_decoder.sv
